>>> src/circular_deque_defines.svh
// Assertion macros for the circular deque.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CDQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("circular_deque: assertion failed");

// next-cycle implication, checked out of reset
`define CDQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("circular_deque: assertion failed");

`endif

>>> src/cdq_pkg.sv
// Shared types, constants and index helpers for the circular deque.
package cdq_pkg;

	localparam int DEPTH = 128;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OCC_W = 8;
	localparam int DATA_W = 32;

	localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
	localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
	localparam logic [1:0] REQ_POP_REAR   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;     // capture incoming request
		logic issue_rd;  // read store at head or tail
		logic commit;    // update indices, store and result register
	} cdq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_pop;
	} cdq_stat_t;

	function automatic idx_t step_back(input idx_t i);
		return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
	endfunction

	function automatic idx_t step_fwd(input idx_t i);
		return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
	endfunction

endpackage

>>> src/cdq_ctrl.sv
// Request sequencing and result handshake for the circular deque.
module cdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  cdq_pkg::cdq_stat_t stat,
	output cdq_pkg::cdq_cmd_t  cmd
);
	import cdq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.latch = in_valid;
			S_EXEC: begin
				if (stat.is_pop) begin
					cmd.issue_rd = 1'b1;
				end else begin
					cmd.commit = out_free;
				end
			end
			S_READ: cmd.commit = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: begin
					if (stat.is_pop) begin
						state_q <= S_READ;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> src/cdq_dpath.sv
// Word store, head/tail indices, count and result register of the deque.
module cdq_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cdq_pkg::cdq_cmd_t          cmd,
	output cdq_pkg::cdq_stat_t         stat,
	input  logic [1:0]                 req_type,
	input  logic signed [31:0]         push_value,
	output logic signed [31:0]         pop_value,
	output logic [1:0]                 status,
	output logic [7:0]                 occupancy,
	output logic                       is_empty,
	output logic                       is_full
);
	import cdq_pkg::*;

	logic [DATA_W-1:0] store_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	logic [1:0]        req_q;
	logic [DATA_W-1:0] val_q;
	idx_t              head_q;
	idx_t              tail_q;
	cnt_t              count_q;

	logic              is_push;
	logic              full;
	logic              empty;
	logic              wr_en;
	idx_t              wr_addr;
	idx_t              head_nxt;
	idx_t              tail_nxt;
	cnt_t              count_nxt;
	logic [1:0]        status_nxt;
	logic [DATA_W-1:0] pop_nxt;

	logic [DATA_W-1:0] pop_value_q;
	logic [1:0]        status_q;
	logic [OCC_W-1:0]  occ_q;
	logic              empty_q;
	logic              full_q;

	assign is_push     = !req_q[1];
	assign stat.is_pop = req_q[1];
	assign full        = (count_q == cnt_t'(DEPTH));
	assign empty       = (count_q == '0);

	always_comb begin
		head_nxt   = head_q;
		tail_nxt   = tail_q;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		pop_nxt    = '0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		if (is_push) begin
			if (full) begin
				status_nxt = ST_FULL;
			end else begin
				wr_en     = 1'b1;
				count_nxt = cnt_t'(count_q + 1'b1);
				if (empty) begin
					head_nxt = '0;
					tail_nxt = '0;
				end else if (req_q == REQ_PUSH_FRONT) begin
					head_nxt = step_back(head_q);
					wr_addr  = head_nxt;
				end else begin
					tail_nxt = step_fwd(tail_q);
					wr_addr  = tail_nxt;
				end
			end
		end else begin
			if (empty) begin
				status_nxt = ST_EMPTY;
			end else begin
				pop_nxt   = rdata_q;
				count_nxt = cnt_t'(count_q - 1'b1);
				if (head_q == tail_q) begin
					head_nxt = '0;
					tail_nxt = '0;
				end else if (req_q == REQ_POP_FRONT) begin
					head_nxt = step_fwd(head_q);
				end else begin
					tail_nxt = step_back(tail_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.commit) begin
			head_q  <= head_nxt;
			tail_q  <= tail_nxt;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_type;
			val_q <= push_value;
		end
		if (cmd.commit) begin
			pop_value_q <= pop_nxt;
			status_q    <= status_nxt;
			occ_q       <= OCC_W'(count_nxt);
			empty_q     <= (count_nxt == '0);
			full_q      <= (count_nxt == cnt_t'(DEPTH));
		end
	end

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			store_q[wr_addr] <= val_q;
		end
		if (cmd.issue_rd) begin
			rdata_q <= store_q[(req_q == REQ_POP_FRONT) ? head_q : tail_q];
		end
	end

	assign pop_value = pop_value_q;
	assign status    = status_q;
	assign occupancy = occ_q;
	assign is_empty  = empty_q;
	assign is_full   = full_q;

endmodule

>>> src/circular_deque.sv
// Circular deque top level: one request accepted when idle, one result per request.
// Holds up to 128 signed 32-bit words in a single-port-write, registered-read store.
// A push is committed from S_EXEC and a pop from S_READ, after the registered read
// of the store issued in S_EXEC; in_stall is high from the acceptance until the
// result is loaded into the output register, which then holds it until out_stall
// drops, while the next request may already be accepted. The store is not cleared
// at reset; only written words are ever read back.
`include "circular_deque_defines.svh"

module circular_deque (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pop_value,
	output logic [1:0]         status,
	output logic [7:0]         occupancy,
	output logic               is_empty,
	output logic               is_full
);
	import cdq_pkg::*;

	cdq_cmd_t  cmd;
	cdq_stat_t stat;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	cdq_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (req_type),
		.push_value (push_value),
		.pop_value  (pop_value),
		.status     (status),
		.occupancy  (occupancy),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	`CDQ_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
	`CDQ_ASSERT_IMPL(a_full_status, out_valid && status == ST_FULL, is_full)
	`CDQ_ASSERT_IMPL(a_empty_status, out_valid && status == ST_EMPTY,
		is_empty && pop_value == 32'sd0)
	`CDQ_ASSERT_IMPL(a_flags_exclusive, out_valid, !(is_empty && is_full))

endmodule
